@@ design/i2c_batch_frame_builder_crc32_top_defines.svh @@
// Assertion macros for the I2C batch frame builder.
// Included by the top level. No other dependencies.
`ifndef I2C_BATCH_FRAME_BUILDER_CRC32_TOP_DEFINES_SVH
`define I2C_BATCH_FRAME_BUILDER_CRC32_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define I2CFB_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("i2cfb assertion failed");
`define I2CFB_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("i2cfb assertion failed");
`else
`define I2CFB_ASSERT_NOW(label, ante, cons)
`define I2CFB_ASSERT_NEXT(label, ante, cons)
`endif

`endif

@@ design/i2cfb_pkg.sv @@
// Shared types, constants and the CRC-32 byte update for the frame builder.
// No dependencies.
package i2cfb_pkg;

   typedef enum logic [1:0] {
      ACT_START  = 2'd0,
      ACT_HEADER = 2'd1,
      ACT_DATA   = 2'd2,
      ACT_END    = 2'd3
   } action_type;

   typedef struct packed {
      action_type kind;
      logic [7:0] b0;
      logic [7:0] b1;
      logic [7:0] b2;
   } item_type;

   localparam logic [31:0] CRC_INIT      = 32'hFFFF_FFFF;
   localparam logic [31:0] CRC_XOROUT    = 32'hFFFF_FFFF;
   localparam logic [31:0] CRC_POLY_REFL = 32'hEDB8_8320;
   localparam logic [7:0]  FLAG_NO_STOP  = 8'h01;
   localparam logic [7:0]  FLAG_STOP     = 8'h00;

   function automatic logic [31:0] crc_feed(input logic [31:0] crc, input logic [7:0] data);
      logic [31:0] c;
      c = crc ^ {24'd0, data};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY_REFL) : (c >> 1);
      end
      return c;
   endfunction

endpackage

@@ design/i2c_batch_frame_builder_crc32_top.sv @@
// Top level of the I2C batch frame builder with CRC-32 trailer.
// An accepted item passes the item register, then the output register sends its
// bytes one per cycle while rsp_tready allows. Start and data items carry one byte,
// headers three and end items four; output register and CRC update are byte-wide.
// Reset is synchronous: CRC returns to all ones, counters and valid flags clear.
// Depends on i2cfb_pkg, i2cfb_item_stage, i2cfb_emitter and the defines header.
`include "i2c_batch_frame_builder_crc32_top_defines.svh"

module i2c_batch_frame_builder_crc32_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // msg_count[7:0], address[14:8], is_read[15], stop_requested[16],
   // length[24:17], data_byte[32:25], zero fill[39:33]
   input  logic [39:0] req_tdata,
   // action[1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // out_byte[7:0]
   output logic [7:0]  rsp_tdata,
   output logic        rsp_tlast,
   // frame_end[0]
   output logic [0:0]  rsp_tuser
);

   logic                item_valid;
   logic                item_take;
   i2cfb_pkg::item_type item;

   i2cfb_item_stage u_item_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take)
   );

   i2cfb_emitter u_emitter (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   `I2CFB_ASSERT_NOW(a_frame_end_is_last, rsp_tvalid && rsp_tuser[0], rsp_tlast)
   `I2CFB_ASSERT_NOW(a_take_needs_item, item_take, item_valid)
   `I2CFB_ASSERT_NOW(a_ready_when_empty, !item_valid, req_tready)
   `I2CFB_ASSERT_NEXT(a_take_fills_output, item_take, rsp_tvalid && rsp_tlast)

endmodule

@@ design/i2cfb_item_stage.sv @@
// Input register of the frame builder: captures one item, formats its bytes
// and tracks the message counters. Depends on i2cfb_pkg.
module i2cfb_item_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [39:0]        req_tdata,
   input  logic [1:0]         req_tuser,
   output logic               item_valid,
   output i2cfb_pkg::item_type item,
   input  logic               item_take
);

   logic                pend_valid_ff, pend_valid_in;
   i2cfb_pkg::item_type pend_ff, pend_in;
   logic [7:0]          msg_index_ff, msg_index_in;
   logic [7:0]          msg_total_ff, msg_total_in;
   logic                accept;
   logic                is_last_msg;
   logic [7:0]          msg_count, length, data_byte;
   logic [6:0]          address;
   logic                is_read, stop_requested;

   assign msg_count      = req_tdata[7:0];
   assign address        = req_tdata[14:8];
   assign is_read        = req_tdata[15];
   assign stop_requested = req_tdata[16];
   assign length         = req_tdata[24:17];
   assign data_byte      = req_tdata[32:25];

   assign req_tready  = !pend_valid_ff || item_take;
   assign accept      = req_tvalid && req_tready;
   assign is_last_msg = ({1'b0, msg_index_ff} + 9'd1) == {1'b0, msg_total_ff};

   always_comb begin
      pend_in       = pend_ff;
      msg_index_in  = msg_index_ff;
      msg_total_in  = msg_total_ff;
      pend_valid_in = item_take ? 1'b0 : pend_valid_ff;
      if (accept) begin
         pend_valid_in = 1'b1;
         pend_in.kind  = i2cfb_pkg::action_type'(req_tuser);
         pend_in.b0    = data_byte;
         pend_in.b1    = 8'd0;
         pend_in.b2    = 8'd0;
         case (i2cfb_pkg::action_type'(req_tuser))
            i2cfb_pkg::ACT_START: begin
               pend_in.b0   = msg_count;
               msg_index_in = 8'd0;
               msg_total_in = msg_count;
            end
            i2cfb_pkg::ACT_HEADER: begin
               pend_in.b0   = {address, is_read};
               pend_in.b1   = (stop_requested || is_last_msg) ? i2cfb_pkg::FLAG_STOP
                                                              : i2cfb_pkg::FLAG_NO_STOP;
               pend_in.b2   = length;
               msg_index_in = msg_index_ff + 8'd1;
            end
            i2cfb_pkg::ACT_END: begin
               msg_index_in = 8'd0;
               msg_total_in = 8'd0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         msg_index_ff  <= 8'd0;
         msg_total_ff  <= 8'd0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         msg_index_ff  <= msg_index_in;
         msg_total_ff  <= msg_total_in;
      end
      pend_ff <= pend_in;
   end

   assign item_valid = pend_valid_ff;
   assign item       = pend_ff;

endmodule

@@ design/i2cfb_emitter.sv @@
// Byte emitter of the frame builder: sends the held item's bytes one per cycle unless
// rsp_tready stalls, via the output register, and keeps the running CRC. Depends on i2cfb_pkg.
module i2cfb_emitter (
   input  logic               clock,
   input  logic               reset,
   input  logic               item_valid,
   input  i2cfb_pkg::item_type item,
   output logic               item_take,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [7:0]         rsp_tdata,
   output logic               rsp_tlast,
   output logic [0:0]         rsp_tuser
);

   logic [1:0]  idx_ff, idx_in;
   logic [31:0] crc_ff, crc_in;
   logic        out_valid_ff, out_valid_in;
   logic [7:0]  out_byte_ff, out_byte_in;
   logic        out_last_ff, out_last_in;
   logic        out_frame_ff, out_frame_in;
   logic        load;
   logic [1:0]  last_idx;
   logic        is_last;
   logic [7:0]  sel_byte;
   logic [31:0] crc_out;

   assign load    = item_valid && (!out_valid_ff || rsp_tready);
   assign crc_out = crc_ff ^ i2cfb_pkg::CRC_XOROUT;

   always_comb begin
      last_idx = 2'd0;
      sel_byte = item.b0;
      case (item.kind)
         i2cfb_pkg::ACT_HEADER: begin
            last_idx = 2'd2;
            case (idx_ff)
               2'd0:    sel_byte = item.b0;
               2'd1:    sel_byte = item.b1;
               default: sel_byte = item.b2;
            endcase
         end
         i2cfb_pkg::ACT_END: begin
            last_idx = 2'd3;
            case (idx_ff)
               2'd0:    sel_byte = crc_out[31:24];
               2'd1:    sel_byte = crc_out[23:16];
               2'd2:    sel_byte = crc_out[15:8];
               default: sel_byte = crc_out[7:0];
            endcase
         end
         default: begin
         end
      endcase
   end

   assign is_last   = idx_ff == last_idx;
   assign item_take = load && is_last;

   always_comb begin
      crc_in = crc_ff;
      if (load) begin
         case (item.kind)
            i2cfb_pkg::ACT_START: crc_in = i2cfb_pkg::crc_feed(i2cfb_pkg::CRC_INIT, sel_byte);
            i2cfb_pkg::ACT_END:   crc_in = is_last ? i2cfb_pkg::CRC_INIT : crc_ff;
            default:              crc_in = i2cfb_pkg::crc_feed(crc_ff, sel_byte);
         endcase
      end
   end

   always_comb begin
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      out_frame_in = out_frame_ff;
      if (load) begin
         idx_in       = is_last ? 2'd0 : idx_ff + 2'd1;
         out_valid_in = 1'b1;
         out_byte_in  = sel_byte;
         out_last_in  = is_last;
         out_frame_in = is_last && (item.kind == i2cfb_pkg::ACT_END);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= 2'd0;
         crc_ff       <= i2cfb_pkg::CRC_INIT;
         out_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         crc_ff       <= crc_in;
         out_valid_ff <= out_valid_in;
      end
      out_byte_ff  <= out_byte_in;
      out_last_ff  <= out_last_in;
      out_frame_ff <= out_frame_in;
   end

   assign rsp_tvalid   = out_valid_ff;
   assign rsp_tdata    = out_byte_ff;
   assign rsp_tlast    = out_last_ff;
   assign rsp_tuser[0] = out_frame_ff;

endmodule

@@ tb/i2c_batch_frame_builder_crc32_top_tb.sv @@
// Self-checking testbench for the I2C batch frame builder with CRC-32 trailer.
// Drives command items, predicts every frame byte and checks each one as it leaves.
// Depends on i2cfb_pkg and i2c_batch_frame_builder_crc32_top.
`timescale 1ns / 100ps

module i2c_batch_frame_builder_crc32_top_tb;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_ITEMS = 200;
   localparam int DRAIN_CYCLES = 16;
   localparam int DIR_ROWS     = 25;

   typedef struct {
      i2cfb_pkg::action_type act;
      logic [7:0]            count;
      logic [6:0]            addr;
      logic                  rd;
      logic                  stp;
      logic [7:0]            len;
      logic [7:0]            data;
   } frame_cmd_type;

   typedef struct {
      logic [7:0] out_byte;
      logic       run_end;
      logic       frame_end;
   } frame_byte_type;

   typedef struct {
      frame_cmd_type cmd;
      bit            typed;
      logic [31:0]   bytes;
   } dir_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;
   logic [0:0]  rsp_tuser;

   frame_byte_type pending_bytes[$];
   logic [31:0]    model_crc;
   logic [7:0]     model_index;
   logic [7:0]     model_total;
   int             errors;
   int             cycle_count;
   int             stall_left;
   bit             quiet;

   // The known CRC-32 check value of "123456789" closes the third frame.
   dir_row_type dir_rows [0:DIR_ROWS-1] = '{
      '{'{i2cfb_pkg::ACT_END, 8'hA5, 7'h5A, 1'b1, 1'b0, 8'h3C, 8'hC3}, 1'b1, 32'h0000_0000},
      '{'{i2cfb_pkg::ACT_DATA, 8'h00, 7'h00, 1'b0, 1'b1, 8'hFF, 8'h00}, 1'b0, 32'h0},
      '{'{i2cfb_pkg::ACT_END, 8'hFF, 7'h7F, 1'b0, 1'b0, 8'h00, 8'hFF}, 1'b0, 32'h0},
      '{'{i2cfb_pkg::ACT_START, 8'h31, 7'h11, 1'b1, 1'b1, 8'h22, 8'h33}, 1'b1, 32'h0000_0031},
      '{'{i2cfb_pkg::ACT_DATA, 8'h00, 7'h00, 1'b0, 1'b0, 8'h00, 8'h32}, 1'b0, 32'h0},
      '{'{i2cfb_pkg::ACT_DATA, 8'h00, 7'h00, 1'b0, 1'b0, 8'h00, 8'h33}, 1'b0, 32'h0},
      '{'{i2cfb_pkg::ACT_DATA, 8'h00, 7'h00, 1'b0, 1'b0, 8'h00, 8'h34}, 1'b0, 32'h0},
      '{'{i2cfb_pkg::ACT_DATA, 8'h00, 7'h00, 1'b0, 1'b0, 8'h00, 8'h35}, 1'b0, 32'h0},
      '{'{i2cfb_pkg::ACT_DATA, 8'h00, 7'h00, 1'b0, 1'b0, 8'h00, 8'h36}, 1'b0, 32'h0},
      '{'{i2cfb_pkg::ACT_DATA, 8'h00, 7'h00, 1'b0, 1'b0, 8'h00, 8'h37}, 1'b0, 32'h0},
      '{'{i2cfb_pkg::ACT_DATA, 8'h00, 7'h00, 1'b0, 1'b0, 8'h00, 8'h38}, 1'b0, 32'h0},
      '{'{i2cfb_pkg::ACT_DATA, 8'h00, 7'h00, 1'b0, 1'b0, 8'h00, 8'h39}, 1'b0, 32'h0},
      '{'{i2cfb_pkg::ACT_END, 8'h00, 7'h00, 1'b0, 1'b0, 8'h00, 8'h00}, 1'b1, 32'hCBF4_3926},
      '{'{i2cfb_pkg::ACT_START, 8'hFF, 7'h00, 1'b0, 1'b0, 8'h00, 8'h00}, 1'b1, 32'h0000_00FF},
      '{'{i2cfb_pkg::ACT_HEADER, 8'h00, 7'h7F, 1'b1, 1'b0, 8'hFF, 8'h00}, 1'b1, 32'h00FF_01FF},
      '{'{i2cfb_pkg::ACT_HEADER, 8'hFF, 7'h00, 1'b0, 1'b1, 8'h00, 8'hFF}, 1'b1, 32'h0000_0000},
      '{'{i2cfb_pkg::ACT_DATA, 8'h00, 7'h7F, 1'b1, 1'b1, 8'hFF, 8'hFF}, 1'b0, 32'h0},
      '{'{i2cfb_pkg::ACT_DATA, 8'hFF, 7'h00, 1'b0, 1'b0, 8'h00, 8'h00}, 1'b0, 32'h0},
      '{'{i2cfb_pkg::ACT_END, 8'h00, 7'h00, 1'b0, 1'b0, 8'h00, 8'h00}, 1'b0, 32'h0},
      '{'{i2cfb_pkg::ACT_START, 8'h01, 7'h00, 1'b0, 1'b0, 8'h00, 8'h00}, 1'b1, 32'h0000_0001},
      '{'{i2cfb_pkg::ACT_HEADER, 8'h00, 7'h55, 1'b0, 1'b0, 8'h03, 8'h00}, 1'b1, 32'h00AA_0003},
      '{'{i2cfb_pkg::ACT_HEADER, 8'h00, 7'h2A, 1'b1, 1'b0, 8'h80, 8'h00}, 1'b1, 32'h0055_0180},
      '{'{i2cfb_pkg::ACT_START, 8'h00, 7'h00, 1'b0, 1'b0, 8'h00, 8'h00}, 1'b1, 32'h0000_0000},
      '{'{i2cfb_pkg::ACT_HEADER, 8'h00, 7'h01, 1'b0, 1'b0, 8'h01, 8'h00}, 1'b1, 32'h0002_0101},
      '{'{i2cfb_pkg::ACT_END, 8'h00, 7'h00, 1'b0, 1'b0, 8'h00, 8'h00}, 1'b0, 32'h0}
   };

   i2c_batch_frame_builder_crc32_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 2);
      if (r < 97) return $urandom_range(3, 6);
      return $urandom_range(10, 30);
   endfunction

   function automatic logic [31:0] crc32_shift_byte(logic [31:0] crc, logic [7:0] b);
      logic [31:0] r;
      int          i;
      r = crc;
      for (i = 0; i < 8; i++) begin
         if (r[0] ^ b[i]) r = (r >> 1) ^ i2cfb_pkg::CRC_POLY_REFL;
         else r = r >> 1;
      end
      return r;
   endfunction

   function automatic frame_cmd_type rand_cmd(i2cfb_pkg::action_type a);
      frame_cmd_type c;
      c.act   = a;
      c.count = 8'($urandom_range(0, 255));
      c.addr  = 7'($urandom_range(0, 127));
      c.rd    = 1'($urandom_range(0, 1));
      c.stp   = 1'($urandom_range(0, 1));
      c.len   = 8'($urandom_range(0, 255));
      c.data  = 8'($urandom_range(0, 255));
      return c;
   endfunction

   task automatic predict_frame_bytes(input frame_cmd_type c, output frame_byte_type res [4],
                                      output int n);
      logic [7:0]  seq [3];
      logic [31:0] crc_out;
      bit          last_msg;
      int          k;
      n = 0;
      case (c.act)
         i2cfb_pkg::ACT_START: begin
            model_crc   = i2cfb_pkg::CRC_INIT;
            model_index = 8'd0;
            model_total = c.count;
            seq[0]      = c.count;
            n           = 1;
         end
         i2cfb_pkg::ACT_HEADER: begin
            last_msg    = ({1'b0, model_index} + 9'd1) == {1'b0, model_total};
            seq[0]      = {c.addr, c.rd};
            seq[1]      = (c.stp || last_msg) ? i2cfb_pkg::FLAG_STOP : i2cfb_pkg::FLAG_NO_STOP;
            seq[2]      = c.len;
            model_index = model_index + 8'd1;
            n           = 3;
         end
         i2cfb_pkg::ACT_DATA: begin
            seq[0] = c.data;
            n      = 1;
         end
         default: begin
            crc_out = model_crc ^ i2cfb_pkg::CRC_XOROUT;
            for (k = 0; k < 4; k++) begin
               res[k].out_byte  = crc_out[31 - 8 * k -: 8];
               res[k].run_end   = (k == 3);
               res[k].frame_end = (k == 3);
            end
            model_crc   = i2cfb_pkg::CRC_INIT;
            model_index = 8'd0;
            model_total = 8'd0;
            n           = 4;
         end
      endcase
      if (c.act != i2cfb_pkg::ACT_END) begin
         for (k = 0; k < n; k++) begin
            model_crc        = crc32_shift_byte(model_crc, seq[k]);
            res[k].out_byte  = seq[k];
            res[k].run_end   = (k == n - 1);
            res[k].frame_end = 1'b0;
         end
      end
   endtask

   task automatic send_item(input frame_cmd_type c, input bit typed, input logic [31:0] word);
      frame_byte_type res [4];
      int             n;
      int             g;
      int             k;
      g = quiet ? 0 : idle_len();
      if (g > 0) begin
         req_tvalid = 1'b0;
         repeat (g) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = c.act;
      req_tdata  = {7'd0, c.data, c.len, c.stp, c.rd, c.addr, c.count};
      do @(posedge clock); while (!req_tready);
      predict_frame_bytes(c, res, n);
      for (k = 0; k < n; k++) begin
         if (typed) res[k].out_byte = word[8 * (n - 1 - k) +: 8];
         pending_bytes.push_back(res[k]);
      end
      @(negedge clock);
   endtask

   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_tready = 1'b0;
         stall_left--;
      end else begin
         rsp_tready = 1'b1;
         if (!quiet && $urandom_range(0, 99) < 30) stall_left = idle_len();
      end
   end

   always @(posedge clock) begin
      frame_byte_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_bytes.size() == 0) begin
            errors++;
            $display("%0t: unexpected byte, expected none, actual %h last %b end %b",
                     $time, rsp_tdata, rsp_tlast, rsp_tuser);
         end else begin
            want = pending_bytes.pop_front();
            if (rsp_tdata !== want.out_byte) begin
               errors++;
               $display("%0t: out_byte expected %h actual %h", $time, want.out_byte,
                        rsp_tdata);
            end
            if (rsp_tlast !== want.run_end) begin
               errors++;
               $display("%0t: run_end expected %b actual %b", $time, want.run_end, rsp_tlast);
            end
            if (rsp_tuser[0] !== want.frame_end) begin
               errors++;
               $display("%0t: frame_end expected %b actual %b", $time, want.frame_end,
                        rsp_tuser[0]);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d bytes outstanding", $time, pending_bytes.size());
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      frame_cmd_type c;
      frame_cmd_type h;
      int            sent;
      int            overrun_at;
      bit            overrun_done;
      int            nmsg;
      int            headers;
      int            ndata;
      int            i;
      int            m;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = i2cfb_pkg::ACT_START;
      rsp_tready   = 1'b0;
      stall_left   = 0;
      quiet        = 1'b0;
      errors       = 0;
      cycle_count  = 0;
      model_crc    = i2cfb_pkg::CRC_INIT;
      model_index  = 8'd0;
      model_total  = 8'd0;
      sent         = 0;
      overrun_done = 1'b0;
      overrun_at   = $urandom_range(20, 150);
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (i = 0; i < DIR_ROWS; i++) begin
         send_item(dir_rows[i].cmd, dir_rows[i].typed, dir_rows[i].bytes);
      end

      while (sent < RANDOM_ITEMS) begin
         quiet = ($urandom_range(0, 4) == 0);
         if (!overrun_done && sent >= overrun_at) begin
            // Enough headers to wrap the message index back past the count.
            overrun_done = 1'b1;
            c = rand_cmd(i2cfb_pkg::ACT_START);
            c.count = 8'($urandom_range(1, 3));
            send_item(c, 1'b0, 32'h0);
            for (m = 0; m < 256 + c.count; m++) begin
               h = rand_cmd(i2cfb_pkg::ACT_HEADER);
               h.rd  = 1'b1;
               h.stp = ($urandom_range(0, 7) == 0);
               send_item(h, 1'b0, 32'h0);
            end
            send_item(rand_cmd(i2cfb_pkg::ACT_END), 1'b0, 32'h0);
            sent = sent + c.count + 258;
         end else if ($urandom_range(0, 4) != 0) begin
            nmsg = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 5);
            c = rand_cmd(i2cfb_pkg::ACT_START);
            c.count = 8'(nmsg);
            send_item(c, 1'b0, 32'h0);
            sent++;
            headers = (nmsg > 6) ? $urandom_range(0, 6) : nmsg;
            for (m = 0; m < headers; m++) begin
               h = rand_cmd(i2cfb_pkg::ACT_HEADER);
               if ($urandom_range(0, 5) != 0) h.len = 8'($urandom_range(0, 4));
               send_item(h, 1'b0, 32'h0);
               sent++;
               ndata = h.rd ? 0 : ((h.len > 8) ? $urandom_range(0, 8) : int'(h.len));
               repeat (ndata) begin
                  send_item(rand_cmd(i2cfb_pkg::ACT_DATA), 1'b0, 32'h0);
                  sent++;
               end
            end
            send_item(rand_cmd(i2cfb_pkg::ACT_END), 1'b0, 32'h0);
            sent++;
         end else begin
            repeat ($urandom_range(1, 6)) begin
               send_item(rand_cmd(i2cfb_pkg::action_type'($urandom_range(0, 3))), 1'b0,
                         32'h0);
               sent++;
            end
         end
      end

      req_tvalid = 1'b0;
      quiet      = 1'b0;
      while (pending_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
